// File: design/phs_pkg.sv
// ----------------------------------------------------------------------------
// phs_pkg
// Types, constants and helpers shared by the polyharmonic spline evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package phs_pkg;

    typedef struct packed {
        logic              kind;
        logic [5:0]        knot_slot;
        logic signed [31:0] knot_pos;
        logic signed [31:0] knot_coef;
        logic signed [31:0] query_x;
    } t_in;

    typedef struct packed {
        logic signed [47:0] interp_value;
        logic signed [47:0] slope;
        logic signed [47:0] curvature;
        logic signed [47:0] jerk;
    } t_out;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] CFG_ACTIVE = 2'd0;
    localparam logic [1:0] CFG_C0     = 2'd1;
    localparam logic [1:0] CFG_C1     = 2'd2;
    localparam logic [1:0] CFG_C2     = 2'd3;

    localparam logic signed [63:0] SAT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN   = 64'sh8000_0000_0000_0001;
    localparam logic signed [63:0] OUT_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_MIN64 = 64'shFFFF_8000_0000_0000;

    localparam logic signed [23:0] LN2_Q = 24'sd45426;

    // ln(1 + i/16) in Q16.16
    function automatic logic [16:0] ln_tab(input logic [4:0] i);
        logic [16:0] v;
        unique case (i)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd3973;
            5'd2:    v = 17'd7719;
            5'd3:    v = 17'd11262;
            5'd4:    v = 17'd14624;
            5'd5:    v = 17'd17821;
            5'd6:    v = 17'd20870;
            5'd7:    v = 17'd23783;
            5'd8:    v = 17'd26573;
            5'd9:    v = 17'd29248;
            5'd10:   v = 17'd31818;
            5'd11:   v = 17'd34292;
            5'd12:   v = 17'd36675;
            5'd13:   v = 17'd38975;
            5'd14:   v = 17'd41196;
            5'd15:   v = 17'd43345;
            default: v = 17'd45426;
        endcase
        return v;
    endfunction

    // add clamped to +-(2^63-1)
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? SAT_MIN : SAT_MAX;
        else if (s[63:0] == 64'h8000_0000_0000_0000)
            return SAT_MIN;
        else
            return s[63:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] a);
        if (a > OUT_MAX64)
            return OUT_MAX64[47:0];
        else if (a < OUT_MIN64)
            return OUT_MIN64[47:0];
        else
            return a[47:0];
    endfunction

endpackage

`default_nettype wire

// File: design/phs_ram.sv
// ----------------------------------------------------------------------------
// phs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module phs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/phs_qmul.sv
// ----------------------------------------------------------------------------
// phs_qmul
// Q16.16 signed multiply of 64 bit operands, truncated toward zero and
// saturated, built from four 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module phs_qmul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    output logic                   o_done,
    output logic signed [63:0]     o_y
);
    import phs_pkg::*;

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg;
    logic [63:0]  r_prod;
    logic [1:0]   r_sh;
    logic [127:0] r_acc;
    logic         r_done;
    logic signed [63:0] r_y;

    logic [31:0]  w_pa;
    logic [31:0]  w_pb;
    logic [1:0]   w_sh;
    logic [127:0] w_addend;
    logic [63:0]  w_mag64;
    logic         w_sat;
    logic signed [63:0] w_mag;

    always_comb begin
        w_pa = (r_cnt == 3'd2 || r_cnt == 3'd3) ? r_ua[63:32] : r_ua[31:0];
        w_pb = (r_cnt == 3'd1 || r_cnt == 3'd3) ? r_ub[63:32] : r_ub[31:0];
        unique case (r_cnt)
            3'd0:    w_sh = 2'd0;
            3'd3:    w_sh = 2'd2;
            default: w_sh = 2'd1;
        endcase
        unique case (r_sh)
            2'd0:    w_addend = {64'd0, r_prod};
            2'd1:    w_addend = {32'd0, r_prod, 32'd0};
            2'd2:    w_addend = {r_prod, 64'd0};
            default: w_addend = '0;
        endcase
        w_mag64 = r_acc[79:16];
        w_sat   = (|r_acc[127:80]) || w_mag64[63];
        w_mag   = w_sat ? SAT_MAX : $signed(w_mag64);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_ua   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
                r_ub   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
                r_neg  <= i_a[63] ^ i_b[63];
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                if (r_cnt <= 3'd3) begin
                    r_prod <= w_pa * w_pb;
                    r_sh   <= w_sh;
                end
                if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                    r_acc <= r_acc + w_addend;
                end
                r_cnt  <= r_cnt + 3'd1;
                r_done <= (r_cnt == 3'd5);
                if (r_cnt == 3'd5) begin
                    r_y    <= r_neg ? -w_mag : w_mag;
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

`default_nettype wire

// File: design/polyharmonic_spline_evaluator.sv
// ----------------------------------------------------------------------------
// polyharmonic_spline_evaluator
// 1-D polyharmonic RBF interpolant (kernel d^4 ln d^2) with quadratic tail:
// value and three derivatives, knots held in centre and weight RAMs.
// ----------------------------------------------------------------------------
// Load word: written straight into both RAMs.
// Query word: per active knot a RAM read, normalize steps for ln and eleven
// multiplies on the shared multiplier; a knot on the query point skips the
// normalize and multiply steps. The tail and output follow the last knot.
// A result waiting at the output does not block loads.
// Reset (synchronous, active low) clears control and config; RAMs keep junk.
// ----------------------------------------------------------------------------
`default_nettype none

module polyharmonic_spline_evaluator #(
    parameter int MAX_KNOTS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire phs_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output phs_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data
);
    import phs_pkg::*;

    localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int CW = $clog2(MAX_KNOTS + 1);

    localparam logic [3:0] ST_D2   = 4'd0;
    localparam logic [3:0] ST_D3   = 4'd1;
    localparam logic [3:0] ST_D4   = 4'd2;
    localparam logic [3:0] ST_TV   = 4'd3;
    localparam logic [3:0] ST_VAL  = 4'd4;
    localparam logic [3:0] ST_TS   = 4'd5;
    localparam logic [3:0] ST_SLP  = 4'd6;
    localparam logic [3:0] ST_TC   = 4'd7;
    localparam logic [3:0] ST_CRV  = 4'd8;
    localparam logic [3:0] ST_TJ   = 4'd9;
    localparam logic [3:0] ST_JRK  = 4'd10;
    localparam logic [3:0] ST_PLIN = 4'd11;
    localparam logic [3:0] ST_PXX  = 4'd12;
    localparam logic [3:0] ST_PSQ  = 4'd13;
    localparam logic [3:0] ST_PSLP = 4'd14;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_DIFF, S_NORM, S_LN, S_MUL, S_WAIT, S_NEXT, S_POLY, S_OUT
    } t_state;

    t_state r_state;
    logic [6:0]         r_active;
    logic signed [31:0] r_c0, r_c1, r_c2;
    logic signed [31:0] r_x;
    logic [CW-1:0]      r_n, r_knot;
    logic [3:0]         r_step;
    logic signed [63:0] r_d, r_d2, r_d3, r_d4, r_w, r_t;
    logic signed [63:0] r_val, r_slp, r_crv, r_jrk;
    logic [32:0]        r_norm;
    logic [5:0]         r_k;
    logic signed [31:0] r_l;
    logic               r_out_valid;
    t_out               r_out_data;

    logic [31:0]        w_cen, w_wgt;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [CW-1:0]      w_n;
    logic signed [32:0] w_diff;
    logic signed [63:0] w_a, w_b, w_y;
    logic               w_done;
    logic signed [31:0] w_ls, w_lc, w_lj, w_ln;
    logic [16:0]        w_t0, w_t1;
    logic [11:0]        w_tdiff;
    logic [27:0]        w_tprod;
    logic [17:0]        w_lnm;
    logic signed [6:0]  w_ke;
    logic signed [23:0] w_kl;
    logic signed [63:0] w_x64, w_2c2;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_we = i_in_valid && o_in_ready && (i_in_data.kind == KIND_LOAD)
                  && (32'(i_in_data.knot_slot) < MAX_KNOTS);
    assign w_waddr = AW'(32'(i_in_data.knot_slot));

    phs_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_cen (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata(i_in_data.knot_pos), .i_raddr(r_knot[AW-1:0]), .o_rdata(w_cen)
    );
    phs_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_wgt (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata(i_in_data.knot_coef), .i_raddr(r_knot[AW-1:0]), .o_rdata(w_wgt)
    );

    phs_qmul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_MUL),
        .i_a(w_a), .i_b(w_b), .o_done(w_done), .o_y(w_y)
    );

    always_comb begin
        if (32'(r_active) > MAX_KNOTS)
            w_n = CW'(MAX_KNOTS);
        else
            w_n = CW'(r_active);
        w_diff = 33'($signed(w_cen)) - 33'(r_x);

        // ln|d| from normalized magnitude
        w_t0    = ln_tab({1'b0, r_norm[31:28]});
        w_t1    = ln_tab(5'({1'b0, r_norm[31:28]}) + 5'd1);
        w_tdiff = 12'(w_t1 - w_t0);
        w_tprod = w_tdiff * r_norm[27:12];
        w_lnm   = 18'(w_t0) + 18'(w_tprod[27:16]);
        w_ke    = $signed({1'b0, r_k}) - 7'sd16;
        w_kl    = 24'(w_ke) * LN2_Q;
        w_ln    = 32'(w_kl) + $signed({14'd0, w_lnm});

        w_ls = -((r_l <<< 2) + 32'sd131072);
        w_lc = (r_l <<< 3) + (r_l <<< 2) + 32'sd917504;
        w_lj = -((r_l <<< 4) + (r_l <<< 3) + 32'sd3407872);
        w_x64 = 64'(r_x);
        w_2c2 = 64'(r_c2) <<< 1;

        unique case (r_step)
            ST_D2:   begin w_a = r_d;         w_b = r_d;        end
            ST_D3:   begin w_a = r_d2;        w_b = r_d;        end
            ST_D4:   begin w_a = r_d2;        w_b = r_d2;       end
            ST_TV:   begin w_a = r_d4;        w_b = 64'(r_l);   end
            ST_TS:   begin w_a = r_d3;        w_b = 64'(w_ls);  end
            ST_TC:   begin w_a = r_d2;        w_b = 64'(w_lc);  end
            ST_TJ:   begin w_a = r_d;         w_b = 64'(w_lj);  end
            ST_PLIN: begin w_a = w_x64;       w_b = 64'(r_c1);  end
            ST_PXX:  begin w_a = w_x64;       w_b = w_x64;      end
            ST_PSQ:  begin w_a = r_t;         w_b = 64'(r_c2);  end
            ST_PSLP: begin w_a = w_x64 <<< 1; w_b = 64'(r_c2);  end
            default: begin w_a = r_w;         w_b = r_t;        end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_c0        <= '0;
            r_c1        <= '0;
            r_c2        <= '0;
            r_out_valid <= 1'b0;
            r_knot      <= '0;
            r_n         <= '0;
            r_step      <= ST_D2;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACTIVE: r_active <= i_cfg_data[6:0];
                    CFG_C0:     r_c0     <= i_cfg_data;
                    CFG_C1:     r_c1     <= i_cfg_data;
                    CFG_C2:     r_c2     <= i_cfg_data;
                    default:    ;
                endcase
            end
            // S_OUT reloads the output word itself
            if (r_out_valid && i_out_ready && r_state != S_OUT)
                r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_in_data.kind == KIND_QUERY) begin
                        r_x    <= i_in_data.query_x;
                        r_n    <= w_n;
                        r_knot <= '0;
                        r_val  <= '0;
                        r_slp  <= '0;
                        r_crv  <= '0;
                        r_jrk  <= '0;
                        r_state <= (w_n == '0) ? S_OUT : S_RD;
                    end
                end
                S_RD: r_state <= S_DIFF;
                S_DIFF: begin
                    r_d    <= 64'(w_diff);
                    r_w    <= 64'($signed(w_wgt));
                    r_norm <= w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
                    r_k    <= 6'd32;
                    r_state <= (w_diff == '0) ? S_NEXT : S_NORM;
                end
                S_NORM: begin
                    if (r_norm[32]) begin
                        r_state <= S_LN;
                    end else begin
                        r_norm <= r_norm << 1;
                        r_k    <= r_k - 6'd1;
                    end
                end
                S_LN: begin
                    r_l     <= w_ln <<< 1;
                    r_step  <= ST_D2;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_done) begin
                        unique case (r_step)
                            ST_D2:   r_d2  <= w_y;
                            ST_D3:   r_d3  <= w_y;
                            ST_D4:   r_d4  <= w_y;
                            ST_VAL:  r_val <= sat_add(r_val, w_y);
                            ST_SLP:  r_slp <= sat_add(r_slp, w_y);
                            ST_CRV:  r_crv <= sat_add(r_crv, w_y);
                            ST_JRK:  r_jrk <= sat_add(r_jrk, w_y);
                            ST_PLIN: r_val <= sat_add(r_val, w_y);
                            ST_PSQ:  r_val <= sat_add(r_val, w_y);
                            ST_PSLP: r_slp <= sat_add(r_slp, w_y);
                            default: r_t   <= w_y;
                        endcase
                        if (r_step == ST_JRK) begin
                            r_state <= S_NEXT;
                        end else if (r_step == ST_PSLP) begin
                            r_state <= S_OUT;
                        end else begin
                            r_step  <= r_step + 4'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_NEXT: begin
                    if (CW'(r_knot + 1'b1) == r_n) begin
                        r_state <= S_POLY;
                    end else begin
                        r_knot  <= r_knot + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_POLY: begin
                    r_val   <= sat_add(r_val, 64'(r_c0));
                    r_slp   <= sat_add(r_slp, 64'(r_c1));
                    r_crv   <= sat_add(r_crv, w_2c2);
                    r_step  <= ST_PLIN;
                    r_state <= S_MUL;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_data.interp_value <= sat48(r_val);
                        r_out_data.slope        <= sat48(r_slp);
                        r_out_data.curvature    <= sat48(r_crv);
                        r_out_data.jerk         <= sat48(r_jrk);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: design/phs_checker.sv
// ----------------------------------------------------------------------------
// phs_checker
// Port level checks on the spline evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module phs_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire phs_pkg::t_in  i_in_data,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire phs_pkg::t_out o_out_data
);
    import phs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word dropped or changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // loads never make a result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.kind == KIND_LOAD && !o_out_valid
        |=> !o_out_valid)
        else $error("result appeared after a load");

    // a query owns the datapath until it finishes
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.kind == KIND_QUERY |=> !o_in_ready)
        else $error("ready during a query");

endmodule

bind polyharmonic_spline_evaluator phs_checker u_phs_checker (.*);

`default_nettype wire

// File: tb/polyharmonic_spline_evaluator_tb.sv
// ----------------------------------------------------------------------------
// polyharmonic_spline_evaluator_tb
// Drives knot loads and queries through the valid/ready input, predicts the
// value and three derivatives per query, and checks every output word in
// order. Config is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module polyharmonic_spline_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import phs_pkg::*;

    localparam int                N_KNOTS    = 64;
    localparam int                IDLE_LIMIT = 200000;
    localparam int                HOLD_LEN   = 3000;
    localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_ACTIVE;
    logic [31:0] i_cfg_data = '0;

    polyharmonic_spline_evaluator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [6:0]        knots_in_use;
    logic signed [63:0] c0_q, c1_q, c2_q;
    logic signed [63:0] centres [N_KNOTS];
    logic signed [63:0] weights [N_KNOTS];

    t_in   pending_words [$];
    t_out  expected_results [$];
    int    errors = 0;
    bit    hold_off = 1'b0;
    bit    hold_done = 1'b0;
    int    hold_cnt = 0;
    int    idle_cycles = 0;

    function automatic logic signed [63:0] clamp_add(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        if (b > 0 && a > SMAX - b) return SMAX;
        if (b < 0 && a < -SMAX - b) return -SMAX;
        return a + b;
    endfunction

    // Q16.16 product, magnitude truncated, clamped
    function automatic logic signed [63:0] fx_mul(logic signed [63:0] a,
                                                  logic signed [63:0] b);
        logic [63:0]  ua, ub;
        logic [127:0] p;
        logic [127:0] m;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = ua * ub;
        m = p >> 16;
        if (m > 128'(SMAX)) m = 128'(SMAX);
        return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    function automatic logic signed [63:0] ln_value(logic [63:0] i);
        case (i)
            0: return 0;      1: return 3973;   2: return 7719;   3: return 11262;
            4: return 14624;  5: return 17821;  6: return 20870;  7: return 23783;
            8: return 26573;  9: return 29248;  10: return 31818; 11: return 34292;
            12: return 36675; 13: return 38975; 14: return 41196; 15: return 43345;
            default: return 45426;
        endcase
    endfunction

    function automatic logic signed [63:0] log_of_square(logic signed [63:0] d);
        logic [63:0] u, frac, idx, rem;
        logic signed [63:0] lo, hi, lnm;
        int k;
        u = d < 0 ? -d : d;
        k = 0;
        for (int i = 0; i <= 40; i++) if (u[i]) k = i;
        if (k > 32) k = 32;
        frac = (u << (32 - k)) & 64'hFFFF_FFFF;
        idx = frac >> 28;
        rem = (frac >> 12) & 64'hFFFF;
        lo = ln_value(idx);
        hi = ln_value(idx + 1);
        lnm = lo + ((hi - lo) * rem >> 16);
        return 2 * ((k - 16) * 64'sd45426 + lnm);
    endfunction

    function automatic logic signed [47:0] to_out(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic t_out spline_at(logic signed [31:0] xq);
        logic signed [63:0] x, v, s, c, j, d, w, l, d2, d3, d4;
        int n;
        t_out r;
        x = xq;
        v = 0; s = 0; c = 0; j = 0;
        n = knots_in_use > N_KNOTS ? N_KNOTS : knots_in_use;
        if (n > 0) begin
            for (int k = 0; k < n; k++) begin
                d = centres[k] - x;
                w = weights[k];
                if (d != 0) begin
                    l = log_of_square(d);
                    d2 = fx_mul(d, d);
                    d3 = fx_mul(d2, d);
                    d4 = fx_mul(d2, d2);
                    v = clamp_add(v, fx_mul(w, fx_mul(d4, l)));
                    s = clamp_add(s, fx_mul(w, fx_mul(d3, -(4 * l + 2 * 65536))));
                    c = clamp_add(c, fx_mul(w, fx_mul(d2, 12 * l + 14 * 65536)));
                    j = clamp_add(j, fx_mul(w, fx_mul(d, -(24 * l + 52 * 65536))));
                end
            end
            v = clamp_add(v, c0_q);
            v = clamp_add(v, fx_mul(x, c1_q));
            v = clamp_add(v, fx_mul(fx_mul(x, x), c2_q));
            s = clamp_add(s, c1_q);
            s = clamp_add(s, fx_mul(2 * x, c2_q));
            c = clamp_add(c, 2 * c2_q);
        end
        r.interp_value = to_out(v);
        r.slope        = to_out(s);
        r.curvature    = to_out(c);
        r.jerk         = to_out(j);
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            if (i_in_data.kind == KIND_LOAD) begin
                centres[i_in_data.knot_slot] <= i_in_data.knot_pos;
                weights[i_in_data.knot_slot] <= i_in_data.knot_coef;
            end else begin
                expected_results.push_back(spline_at(i_in_data.query_x));
            end
        end
        if (!i_in_valid || o_in_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                i_in_data <= pending_words.pop_front();
                i_in_valid <= 1'b1;
                send_gap <= gap_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                t_out e;
                e = expected_results.pop_front();
                if (o_out_data.interp_value !== e.interp_value) begin
                    $error("interp_value exp %0d got %0d", e.interp_value,
                           o_out_data.interp_value);
                    errors++;
                end
                if (o_out_data.slope !== e.slope) begin
                    $error("slope exp %0d got %0d", e.slope, o_out_data.slope);
                    errors++;
                end
                if (o_out_data.curvature !== e.curvature) begin
                    $error("curvature exp %0d got %0d", e.curvature,
                           o_out_data.curvature);
                    errors++;
                end
                if (o_out_data.jerk !== e.jerk) begin
                    $error("jerk exp %0d got %0d", e.jerk, o_out_data.jerk);
                    errors++;
                end
            end
        end
        if (hold_off && !hold_done) begin
            i_out_ready <= 1'b0;
            if (hold_cnt >= HOLD_LEN - 1)
                hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_left <= gap_len();
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("polyharmonic_spline_evaluator_tb: done, errors");
            $finish;
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ACTIVE: knots_in_use = val[6:0];
            CFG_C0:     c0_q = $signed(val);
            CFG_C1:     c1_q = $signed(val);
            default:    c2_q = $signed(val);
        endcase
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !i_in_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_in load_word(int slot, logic [31:0] p, logic [31:0] w);
        t_in t;
        t = '0;
        t.kind = KIND_LOAD;
        t.knot_slot = 6'(slot);
        t.knot_pos = p;
        t.knot_coef = w;
        return t;
    endfunction

    function automatic t_in query_word(logic [31:0] x);
        t_in t;
        t = '0;
        t.knot_slot = 6'($urandom());
        t.knot_pos = $urandom();
        t.knot_coef = $urandom();
        t.kind = KIND_QUERY;
        t.query_x = x;
        return t;
    endfunction

    // mostly small magnitudes so sums stay in range; sometimes full-scale
    function automatic logic [31:0] rnd_q();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
        if (r < 8) return $urandom();
        return r == 8 ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    // knots kept small in random phases so queries stay quick
    task automatic random_phase(int nk, int items);
        int slot;
        cfg_write(CFG_ACTIVE, nk);
        cfg_write(CFG_C0, rnd_q());
        cfg_write(CFG_C1, rnd_q());
        cfg_write(CFG_C2, rnd_q());
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                slot = $urandom_range(0, 63);
                pending_words.push_back(load_word(slot, rnd_q(), rnd_q()));
            end else begin
                pending_words.push_back(query_word(rnd_q()));
            end
        end
        drain();
    endtask

    initial begin
        c0_q = 0; c1_q = 0; c2_q = 0; knots_in_use = 0;
        for (int k = 0; k < N_KNOTS; k++) begin
            centres[k] = 0; weights[k] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero knots: all-zero result even with a tail set
        cfg_write(CFG_C0, 32'h7FFF_FFFF);
        pending_words.push_back(query_word(32'h0001_0000));
        drain();

        // load every slot so any active count is legal
        for (int k = 0; k < N_KNOTS; k++)
            pending_words.push_back(load_word(k, rnd_q(), rnd_q()));
        pending_words.push_back(load_word(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_words.push_back(load_word(1, 32'h8000_0000, 32'h8000_0000));
        pending_words.push_back(load_word(2, 32'h0001_0000, 32'h0002_0000));
        drain();

        // more than the table: counts as full table
        cfg_write(CFG_ACTIVE, 7'd127);
        cfg_write(CFG_C1, 32'h8000_0000);
        cfg_write(CFG_C2, 32'h7FFF_FFFF);
        pending_words.push_back(query_word(32'h0001_0000)); // hits a knot exactly
        pending_words.push_back(query_word(32'h7FFF_FFFF));
        pending_words.push_back(query_word(32'h8000_0000));
        pending_words.push_back(query_word(32'h0));
        drain();

        cfg_write(CFG_ACTIVE, 7'd64);
        cfg_write(CFG_C0, 32'h8000_0000);
        cfg_write(CFG_C1, 32'h0);
        cfg_write(CFG_C2, 32'h8000_0000);
        pending_words.push_back(query_word(32'hFFFF_FFFF));
        pending_words.push_back(query_word(32'h0000_0001));
        drain();

        // receiver holds off while the sender keeps going
        cfg_write(CFG_ACTIVE, 7'd1);
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++)
            pending_words.push_back(query_word(rnd_q()));
        wait (hold_done);
        hold_off = 1'b0;
        drain();

        random_phase(2, 170);
        random_phase(1, 170);
        random_phase(4, 170);
        random_phase(3, 170);

        if (errors == 0)
            $display("polyharmonic_spline_evaluator_tb: done, clean");
        else
            $display("polyharmonic_spline_evaluator_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
